### design/ftm_pkg.sv
package ftm_pkg;

   // Field widths fixed by the interface.
   localparam int TIME_W = 32;
   localparam int FPS_W  = 20;
   localparam int RUN_W  = 16;
   localparam int GRADE_W = 3;

   // Numerator of the rate calculation: one second in microseconds.
   localparam logic [FPS_W-1:0] FPS_NUMERATOR = 20'd1000000;

   // Consecutive slow frames that raise the slow warning.
   localparam logic [RUN_W-1:0] SLOW_RUN_LEVEL = 16'd10;

   // Rate thresholds for the grade.
   localparam logic [FPS_W-1:0] FPS_GRADE_A  = 20'd60;
   localparam logic [FPS_W-1:0] FPS_GRADE_AM = 20'd58;
   localparam logic [FPS_W-1:0] FPS_GRADE_BP = 20'd55;
   localparam logic [FPS_W-1:0] FPS_GRADE_B  = 20'd50;
   localparam logic [FPS_W-1:0] FPS_GRADE_C  = 20'd45;
   localparam logic [FPS_W-1:0] FPS_GRADE_D  = 20'd30;

   // Grade codes.
   localparam logic [GRADE_W-1:0] GRADE_APLUS  = 3'd0;
   localparam logic [GRADE_W-1:0] GRADE_A      = 3'd1;
   localparam logic [GRADE_W-1:0] GRADE_AMINUS = 3'd2;
   localparam logic [GRADE_W-1:0] GRADE_BPLUS  = 3'd3;
   localparam logic [GRADE_W-1:0] GRADE_B      = 3'd4;
   localparam logic [GRADE_W-1:0] GRADE_C      = 3'd5;
   localparam logic [GRADE_W-1:0] GRADE_D      = 3'd6;
   localparam logic [GRADE_W-1:0] GRADE_F      = 3'd7;

   // Item operations.
   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_UPDATE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   // Configuration register indexes.
   localparam logic REG_SLOW_LIMIT = 1'b0;
   localparam logic REG_MIN_FPS    = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [TIME_W-1:0] SLOW_LIMIT_RESET = 32'd18000;
   localparam logic [FPS_W-1:0]  MIN_FPS_RESET    = 20'd55;

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### design/ftm_ram.sv
module ftm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/ftm_div.sv
module ftm_div #(
   parameter int DIVIDEND_W = 38
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [DIVIDEND_W-1:0]                dividend,
   input  logic [ftm_pkg::TIME_W-1:0]           divisor,
   input  logic [$clog2(DIVIDEND_W+1)-1:0]      steps,
   output ftm_pkg::div_status_type              status,
   output logic [DIVIDEND_W-1:0]                quotient
);

   import ftm_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [TIME_W-1:0]     den_ff, den_in;
   logic [STEP_W-1:0]     left_ff, left_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [TIME_W:0]       trial;
   logic                  fits;

   // One quotient bit a cycle, most significant first.
   assign trial = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      left_in = left_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         left_in = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = {num_ff[DIVIDEND_W-2:0], 1'b0};
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? TIME_W'(trial - {1'b0, den_ff}) : trial[TIME_W-1:0];
         left_in = left_ff - STEP_W'(1);
         if (left_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      left_ff <= left_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

### design/frame_time_monitor.sv
// Channel   Direction  Contents
// req       in         tuser: opcode; tdata: frame_time
// rsp       out        tdata: status after the item, one beat per request beat
// csr       in         write enable, register index, write data
//
// A record beat passes through the REC, ADD and EMIT states to the result register.
// For an update beat with frames in the window, the shared bit-serial divider forms
// the window average, then the rate. Clear and no-operation beats go straight to EMIT.
// Reset is synchronous and needs no clearing pass; history entries are only used once
// written since the last clear. A new request beat is taken while a finished result
// still waits in the output register.
module frame_time_monitor #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request beat.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ftm_pkg::TIME_W-1:0]  req_tdata,   // [31:0] frame_time
   input  logic [1:0]                  req_tuser,   // [1:0] opcode
   // Result beat.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [19:0] fps, [51:20] avg_time_us, [83:52] min_time_us, [115:84] max_time_us,
   // [147:116] frame_total, [179:148] drop_total, [180] low_fps_flag,
   // [181] slow_run_flag, [182] healthy, [185:183] grade, [191:186] zero
   output logic [191:0]                rsp_tdata,
   // Configuration writes.
   input  logic                        csr_we,
   input  logic                        csr_addr,
   input  logic [ftm_pkg::TIME_W-1:0]  csr_wdata
);

   import ftm_pkg::*;

   localparam int SLOT_W = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = TIME_W + $clog2(HISTORY_DEPTH);
   localparam int STEP_W = $clog2(SUM_W + 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_REC  = 7'b0000010,
      ST_ADD  = 7'b0000100,
      ST_AVG  = 7'b0001000,
      ST_FPS  = 7'b0010000,
      ST_FLAG = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;

   logic [TIME_W-1:0]  slow_limit_ff, slow_limit_in;
   logic [FPS_W-1:0]   min_fps_ff, min_fps_in;

   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TIME_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0]  drop_ff, drop_in;
   logic [TIME_W-1:0]  min_ff, min_in;
   logic [TIME_W-1:0]  max_ff, max_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               slow_warn_ff, slow_warn_in;
   logic               fps_warn_ff, fps_warn_in;
   logic [FPS_W-1:0]   fps_ff, fps_in;
   logic [TIME_W-1:0]  avg_ff, avg_in;
   logic [TIME_W-1:0]  time_ff, time_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [191:0]       rsp_data_ff, rsp_data_in;

   logic               req_accept;
   opcode_type         req_op;
   logic               window_full;
   logic [CNT_W-1:0]   window_len;
   logic [RUN_W-1:0]   run_next;

   logic               ram_we;
   logic               ram_re;
   logic [TIME_W-1:0]  ram_rdata;

   logic               div_start;
   logic [SUM_W-1:0]   div_dividend;
   logic [TIME_W-1:0]  div_divisor;
   logic [STEP_W-1:0]  div_steps;
   div_status_type     div_status;
   logic [SUM_W-1:0]   div_quotient;

   logic [TIME_W-1:0]  total_floor;
   logic [TIME_W+5:0]  drop_x20;
   logic               rate_ok;
   logic               healthy;
   logic [GRADE_W-1:0] grade;

   assign req_tready = state_ff == ST_IDLE;
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = opcode_type'(req_tuser);

   // Frames in the averaging window.
   assign window_full = count_ff >= TIME_W'(HISTORY_DEPTH);
   assign window_len  = window_full ? CNT_W'(HISTORY_DEPTH) : count_ff[CNT_W-1:0];
   assign run_next    = (run_ff == '1) ? run_ff : run_ff + RUN_W'(1);

   // History ring.
   assign ram_re = req_accept && (req_op == OP_RECORD);
   assign ram_we = state_ff == ST_REC;

   ftm_ram #(
      .WIDTH (TIME_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (time_ff),
      .re    (ram_re),
      .raddr (slot_ff),
      .rdata (ram_rdata)
   );

   // Shared divider: window average first, then the frame rate.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = sum_ff;
      div_divisor  = TIME_W'(window_len);
      div_steps    = STEP_W'(SUM_W);
      if (req_accept && (req_op == OP_UPDATE) && (window_len != '0)) begin
         div_start = 1'b1;
      end else if ((state_ff == ST_AVG) && div_status.done
                   && (div_quotient[TIME_W-1:0] != '0)) begin
         div_start    = 1'b1;
         div_dividend = {FPS_NUMERATOR, {(SUM_W - FPS_W){1'b0}}};
         div_divisor  = div_quotient[TIME_W-1:0];
         div_steps    = STEP_W'(FPS_W);
      end
   end

   ftm_div #(
      .DIVIDEND_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Health and grade from the current statistics.
   assign total_floor = (count_ff == '0) ? TIME_W'(1) : count_ff;
   assign drop_x20    = {2'b00, drop_ff, 4'b0000} + {4'b0000, drop_ff, 2'b00};
   assign rate_ok     = drop_x20 < {6'b000000, total_floor};
   assign healthy     = (fps_ff >= min_fps_ff) && !slow_warn_ff && rate_ok;

   always_comb begin
      if (fps_ff >= FPS_GRADE_A) begin
         grade = (drop_ff == '0) ? GRADE_APLUS : GRADE_A;
      end else if (fps_ff >= FPS_GRADE_AM) begin
         grade = GRADE_AMINUS;
      end else if (fps_ff >= FPS_GRADE_BP) begin
         grade = GRADE_BPLUS;
      end else if (fps_ff >= FPS_GRADE_B) begin
         grade = GRADE_B;
      end else if (fps_ff >= FPS_GRADE_C) begin
         grade = GRADE_C;
      end else if (fps_ff >= FPS_GRADE_D) begin
         grade = GRADE_D;
      end else begin
         grade = GRADE_F;
      end
   end

   // Configuration writes.
   always_comb begin
      slow_limit_in = slow_limit_ff;
      min_fps_in    = min_fps_ff;
      if (csr_we && (csr_addr == REG_SLOW_LIMIT)) begin
         slow_limit_in = csr_wdata;
      end
      if (csr_we && (csr_addr == REG_MIN_FPS)) begin
         min_fps_in = csr_wdata[FPS_W-1:0];
      end
   end

   // Sequencer and statistics.
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      run_in       = run_ff;
      slow_warn_in = slow_warn_ff;
      fps_warn_in  = fps_warn_ff;
      fps_in       = fps_ff;
      avg_in       = avg_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               time_in = req_tdata;
               case (req_op)
                  OP_RECORD: begin
                     state_in = ST_REC;
                  end
                  OP_UPDATE: begin
                     if (window_len == '0) begin
                        avg_in   = '0;
                        state_in = ST_FLAG;
                     end else begin
                        state_in = ST_AVG;
                     end
                  end
                  OP_CLEAR: begin
                     slot_in      = '0;
                     sum_in       = '0;
                     count_in     = '0;
                     drop_in      = '0;
                     min_in       = '1;
                     max_in       = '0;
                     run_in       = '0;
                     slow_warn_in = 1'b0;
                     fps_warn_in  = 1'b0;
                     state_in     = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_REC: begin
            // Oldest entry leaves the window once it is full.
            if (window_full) begin
               sum_in = sum_ff - SUM_W'(ram_rdata);
            end
            slot_in  = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
            count_in = (count_ff == '1) ? count_ff : count_ff + TIME_W'(1);
            if (time_ff < min_ff) begin
               min_in = time_ff;
            end
            if (time_ff > max_ff) begin
               max_in = time_ff;
            end
            if (time_ff > slow_limit_ff) begin
               drop_in = (drop_ff == '1) ? drop_ff : drop_ff + TIME_W'(1);
               run_in  = run_next;
               if (run_next >= SLOW_RUN_LEVEL) begin
                  slow_warn_in = 1'b1;
               end
            end else begin
               run_in       = '0;
               slow_warn_in = 1'b0;
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in   = sum_ff + SUM_W'(time_ff);
            state_in = ST_EMIT;
         end
         ST_AVG: begin
            if (div_status.done) begin
               avg_in   = div_quotient[TIME_W-1:0];
               state_in = (div_quotient[TIME_W-1:0] != '0) ? ST_FPS : ST_FLAG;
            end
         end
         ST_FPS: begin
            if (div_status.done) begin
               fps_in   = div_quotient[FPS_W-1:0];
               state_in = ST_FLAG;
            end
         end
         ST_FLAG: begin
            fps_warn_in = fps_ff < min_fps_ff;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // Load the result register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b000000, grade, healthy, slow_warn_ff, fps_warn_ff,
                               drop_ff, count_ff, max_ff, min_ff, avg_ff, fps_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slow_limit_ff <= SLOW_LIMIT_RESET;
         min_fps_ff    <= MIN_FPS_RESET;
         slot_ff       <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         drop_ff       <= '0;
         min_ff        <= '1;
         max_ff        <= '0;
         run_ff        <= '0;
         slow_warn_ff  <= 1'b0;
         fps_warn_ff   <= 1'b0;
         fps_ff        <= '0;
         avg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slow_limit_ff <= slow_limit_in;
         min_fps_ff    <= min_fps_in;
         slot_ff       <= slot_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         drop_ff       <= drop_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         run_ff        <= run_in;
         slow_warn_ff  <= slow_warn_in;
         fps_warn_ff   <= fps_warn_in;
         fps_ff        <= fps_in;
         avg_ff        <= avg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      time_ff     <= time_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### test/frame_stats_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels of the frame-time monitor.
// It keeps its own copy of the statistics, predicts the status word for every
// request beat and compares each result beat with the oldest prediction.
module frame_stats_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [ftm_pkg::TIME_W-1:0] req_tdata,
   input  logic [1:0]                 req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [191:0]               rsp_tdata,
   input  logic                       csr_we,
   input  logic                       csr_addr,
   input  logic [ftm_pkg::TIME_W-1:0] csr_wdata,
   output int                         outstanding,
   output int                         mismatches,
   output int                         checked
);

   import ftm_pkg::*;

   localparam int RING_DEPTH = 64;

   // Status word as it sits in rsp_tdata, fps in the lowest bits.
   typedef struct packed {
      logic [GRADE_W-1:0] grade;
      logic               healthy;
      logic               slow_run_flag;
      logic               low_fps_flag;
      logic [TIME_W-1:0]  drop_total;
      logic [TIME_W-1:0]  frame_total;
      logic [TIME_W-1:0]  max_time_us;
      logic [TIME_W-1:0]  min_time_us;
      logic [TIME_W-1:0]  avg_time_us;
      logic [FPS_W-1:0]   fps;
   } frame_status_type;

   localparam int STATUS_W = $bits(frame_status_type);

   // Register copies.
   logic [TIME_W-1:0] slow_limit;
   logic [FPS_W-1:0]  fps_floor;

   // Statistics copy.
   logic [TIME_W-1:0] ring [RING_DEPTH];
   int unsigned       ring_slot;
   logic [37:0]       window_sum;
   logic [TIME_W-1:0] frames;
   logic [TIME_W-1:0] drops;
   logic [TIME_W-1:0] shortest;
   logic [TIME_W-1:0] longest;
   logic [RUN_W-1:0]  slow_run;
   logic              slow_warn;
   logic              fps_low;
   logic [FPS_W-1:0]  rate;
   logic [TIME_W-1:0] average;

   frame_status_type status_q [$];
   int               fault_total = 0;
   int               beats_seen = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: result beat %0d, %s: got %0d, expected %0d",
               $realtime, beats_seen, what, got, want);
      fault_total++;
   endtask

   // Clear keeps the rate and the average.
   task automatic clear_stats;
      foreach (ring[i]) ring[i] = '0;
      ring_slot = 0;
      window_sum = '0;
      frames = '0;
      drops = '0;
      shortest = '1;
      longest = '0;
      slow_run = '0;
      slow_warn = 1'b0;
      fps_low = 1'b0;
   endtask

   // A recorded frame replaces the oldest ring entry once the window is full.
   task automatic log_frame(input logic [TIME_W-1:0] t);
      if (frames >= RING_DEPTH) window_sum = window_sum - ring[ring_slot];
      window_sum = window_sum + t;
      ring[ring_slot] = t;
      ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
      if (frames != '1) frames = frames + 1'b1;
      if (t < shortest) shortest = t;
      if (t > longest) longest = t;
      if (t > slow_limit) begin
         if (drops != '1) drops = drops + 1'b1;
         if (slow_run != '1) slow_run = slow_run + 1'b1;
         if (slow_run >= SLOW_RUN_LEVEL) slow_warn = 1'b1;
      end else begin
         slow_run = '0;
         slow_warn = 1'b0;
      end
   endtask

   // Average over the filled part of the window, then the rate when it is nonzero.
   task automatic refresh_rate;
      logic [37:0] count;
      count = (frames < RING_DEPTH) ? frames : RING_DEPTH;
      average = (count != '0) ? window_sum / count : '0;
      if (average != '0) rate = FPS_NUMERATOR / average;
      fps_low = rate < fps_floor;
   endtask

   function automatic frame_status_type status_now();
      frame_status_type s;
      logic [63:0]      drop_scaled;
      logic [63:0]      total_scaled;
      s.fps = rate;
      s.avg_time_us = average;
      s.min_time_us = shortest;
      s.max_time_us = longest;
      s.frame_total = frames;
      s.drop_total = drops;
      s.low_fps_flag = fps_low;
      s.slow_run_flag = slow_warn;
      drop_scaled = drops * 64'd100;
      total_scaled = ((frames == '0) ? 64'd1 : frames) * 64'd5;
      s.healthy = (rate >= fps_floor) && !slow_warn && (drop_scaled < total_scaled);
      if (rate >= FPS_GRADE_A) s.grade = (drops == '0) ? GRADE_APLUS : GRADE_A;
      else if (rate >= FPS_GRADE_AM) s.grade = GRADE_AMINUS;
      else if (rate >= FPS_GRADE_BP) s.grade = GRADE_BPLUS;
      else if (rate >= FPS_GRADE_B) s.grade = GRADE_B;
      else if (rate >= FPS_GRADE_C) s.grade = GRADE_C;
      else if (rate >= FPS_GRADE_D) s.grade = GRADE_D;
      else s.grade = GRADE_F;
      return s;
   endfunction

   task automatic compare_status(input frame_status_type got, input frame_status_type want,
                                 input logic [191-STATUS_W:0] padding);
      if (got.fps != want.fps) report_mismatch("fps", got.fps, want.fps);
      if (got.avg_time_us != want.avg_time_us)
         report_mismatch("avg_time_us", got.avg_time_us, want.avg_time_us);
      if (got.min_time_us != want.min_time_us)
         report_mismatch("min_time_us", got.min_time_us, want.min_time_us);
      if (got.max_time_us != want.max_time_us)
         report_mismatch("max_time_us", got.max_time_us, want.max_time_us);
      if (got.frame_total != want.frame_total)
         report_mismatch("frame_total", got.frame_total, want.frame_total);
      if (got.drop_total != want.drop_total)
         report_mismatch("drop_total", got.drop_total, want.drop_total);
      if (got.low_fps_flag != want.low_fps_flag)
         report_mismatch("low_fps_flag", got.low_fps_flag, want.low_fps_flag);
      if (got.slow_run_flag != want.slow_run_flag)
         report_mismatch("slow_run_flag", got.slow_run_flag, want.slow_run_flag);
      if (got.healthy != want.healthy)
         report_mismatch("healthy", got.healthy, want.healthy);
      if (got.grade != want.grade) report_mismatch("grade", got.grade, want.grade);
      if (padding != '0) report_mismatch("padding bits", padding, 0);
   endtask

   // All channels are sampled at the rising edge, before anything updates there.
   always @(posedge clock) begin : watch
      frame_status_type got;
      if (reset) begin
         slow_limit = SLOW_LIMIT_RESET;
         fps_floor = MIN_FPS_RESET;
         clear_stats;
         rate = '0;
         average = '0;
         status_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_SLOW_LIMIT: slow_limit = csr_wdata;
               REG_MIN_FPS: fps_floor = csr_wdata[FPS_W-1:0];
               default: ;
            endcase
         end

         // A result beat is matched against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            got = rsp_tdata[STATUS_W-1:0];
            if (status_q.size() == 0)
               report_mismatch("beat with no request waiting", 1, 0);
            else
               compare_status(got, status_q.pop_front(), rsp_tdata[191:STATUS_W]);
         end

         // Each request beat yields exactly one status beat.
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_RECORD: log_frame(req_tdata);
               OP_UPDATE: refresh_rate;
               OP_CLEAR: clear_stats;
               OP_NOP: ;
               default: ;
            endcase
            status_q.push_back(status_now());
         end
      end
      outstanding <= status_q.size();
      mismatches <= fault_total;
      checked <= beats_seen;
   end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import ftm_pkg::*;

   localparam int IDLE_PERCENT = 34;
   localparam int PHASES = 7;
   localparam int PHASE_BEATS = 218;
   localparam int TAIL_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 4000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [TIME_W-1:0] req_tdata = '0;
   logic [1:0]        req_tuser = OP_NOP;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [191:0]      rsp_tdata;
   logic              csr_we = 1'b0;
   logic              csr_addr = REG_SLOW_LIMIT;
   logic [TIME_W-1:0] csr_wdata = '0;

   int outstanding;
   int mismatches;
   int checked;

   // Both sides stall at random unless the steady stretch is on.
   logic              steady = 1'b0;
   logic [TIME_W-1:0] limit_now = SLOW_LIMIT_RESET;
   int                sent [4];
   int                settings = 0;
   int                quiet_cycles = 0;
   int                profile = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   frame_time_monitor #(
      .HISTORY_DEPTH(64)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   frame_stats_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches),
      .checked     (checked)
   );

   // Result side back-pressure.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one request beat after a random gap and holds it until taken.
   task automatic send_beat(input opcode_type op, input logic [TIME_W-1:0] t);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= t;
      do @(posedge clock); while (!req_tready);
      sent[op]++;
   endtask

   // Holds off the sender until every predicted status beat has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(input logic idx, input logic [TIME_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      if (idx == REG_SLOW_LIMIT) limit_now = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input logic [TIME_W-1:0] limit, input logic [FPS_W-1:0] floor);
      drain;
      write_register(REG_SLOW_LIMIT, limit);
      write_register(REG_MIN_FPS, floor);
      settings++;
   endtask

   function automatic logic [TIME_W-1:0] slow_frame_time();
      if (limit_now > 32'hFFFF_0000) return '1;
      return limit_now + $urandom_range(1, 30000);
   endfunction

   // Frame times by traffic profile: smooth, mixed, slow burst, or edge values.
   function automatic logic [TIME_W-1:0] frame_time_for(input int kind);
      case (kind)
         0: begin
            if ($urandom_range(0, 99) < 3) return slow_frame_time();
            return $urandom_range(15000, 17900);
         end
         1: return $urandom_range(8000, 40000);
         2: return slow_frame_time();
         default: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return 1;
               2: return '1;
               3: return limit_now;
               4: return limit_now + 1'b1;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   initial begin : stimulus
      int         pick;
      opcode_type op;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset register values.
      send_beat(OP_NOP, '0);
      send_beat(OP_UPDATE, '0);
      send_beat(OP_RECORD, '0);
      send_beat(OP_RECORD, '1);
      send_beat(OP_UPDATE, '0);
      send_beat(OP_CLEAR, '0);
      send_beat(OP_UPDATE, '0);
      send_beat(OP_RECORD, 1);
      send_beat(OP_UPDATE, '0);
      // Eleven slow frames raise the slow warning; a fast one clears it.
      repeat (11) send_beat(OP_RECORD, 20000);
      send_beat(OP_RECORD, 16000);
      send_beat(OP_UPDATE, '0);
      send_beat(OP_NOP, '1);
      send_beat(OP_CLEAR, '0);

      // Random part, one register setting per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: apply_setting(SLOW_LIMIT_RESET, MIN_FPS_RESET);
            1: apply_setting('0, '0);
            2: apply_setting('1, FPS_NUMERATOR);
            3: apply_setting(16667, 60);
            4: apply_setting($urandom_range(12000, 30000), $urandom_range(20, 70));
            5: apply_setting($urandom(), $urandom_range(0, 1000000));
            default: apply_setting(20000, 45);
         endcase
         steady <= (phase == 3);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 99) < 2) profile = $urandom_range(0, 3);
            if ($urandom_range(0, 149) == 0) drain;
            pick = $urandom_range(0, 399);
            if (pick < 300) op = OP_RECORD;
            else if (pick < 376) op = OP_UPDATE;
            else if (pick < 396) op = OP_NOP;
            else op = OP_CLEAR;
            send_beat(op, (op == OP_RECORD) ? frame_time_for(profile) : $urandom());
         end
      end

      drain;
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d record, %0d update, %0d clear and %0d no-op beats over %0d settings.",
               sent[OP_RECORD], sent[OP_UPDATE], sent[OP_CLEAR], sent[OP_NOP], settings);
      $display("Compared %0d status beats field by field with the predicted statistics.",
               checked);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
